### sv/tmq_pkg.sv
`default_nettype none
package tmq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TagWidthDefault   = 16;

  localparam logic [2:0] FUNC_ENQUEUE      = 3'd0;
  localparam logic [2:0] FUNC_POP_DUE      = 3'd1;
  localparam logic [2:0] FUNC_QUERY        = 3'd2;
  localparam logic [2:0] FUNC_REMOVE_FIRST = 3'd3;
  localparam logic [2:0] FUNC_REMOVE_ALL   = 3'd4;
  localparam logic [2:0] FUNC_QUIT_SAFE    = 3'd5;
  localparam logic [2:0] FUNC_QUIT_NOW     = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_TARGET = 3'd1;
  localparam logic [2:0] ST_QUIT      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_NOT_DUE   = 3'd5;
  localparam logic [2:0] ST_FOUND     = 3'd6;
  localparam logic [2:0] ST_NOT_FOUND = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] time_value;
    logic [15:0] msg_id;
    logic [31:0] what;
    logic [31:0] what_max;
    logic [31:0] arg1;
    logic [31:0] arg2;
    logic [15:0] target_id;
    logic [15:0] runnable_id;
    logic [15:0] callback_id;
    logic [6:0]  match_mask;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_msg_id;
    logic [31:0] out_what;
    logic [31:0] out_arg1;
    logic [31:0] out_arg2;
    logic [15:0] out_target_id;
    logic [15:0] out_runnable_id;
    logic [15:0] out_callback_id;
    logic [63:0] wait_time;
    logic [4:0]  queue_count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch request, zero scan index
    logic scan_inc;  // advance scan index
    logic ins_write; // write request at scan index, shift tail up
    logic del_slot;  // delete entry at scan index
    logic clear;     // empty the queue
    logic set_safe;
    logic set_exit;
    logic hit_set;
    logic rsp_load;  // capture response with given status
    logic pop_out;   // response carries head entry
    logic wait_out;  // response carries wait time
    logic [2:0] status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] func;
    logic tgt_zero;
    logic safe;
    logic exited;
    logic full;
    logic empty;
    logic scan_end;  // scan index at count
    logic head_early; // request time zero or earlier than head
    logic slot_le;    // slot time <= request time
    logic head_due;
    logic match;
    logic hit;
  } sts_t;

endpackage
`default_nettype wire

### sv/tmq_datapath.sv
`default_nettype none
module tmq_datapath import tmq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault,
  parameter int unsigned TagWidth   = TagWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  req_t      req_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output rsp_t      rsp_o
);

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [63:0]         tm;
    logic [31:0]         what;
    logic [31:0]         a1;
    logic [31:0]         a2;
    logic [TagWidth-1:0] id;
    logic [TagWidth-1:0] tgt;
    logic [TagWidth-1:0] run;
    logic [TagWidth-1:0] cb;
  } ent_t;

  ent_t ent_q [QueueDepth];
  ent_t ent_d [QueueDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic safe_q, safe_d, exit_q, exit_d, hit_q, hit_d;
  req_t r_q;
  rsp_t rsp_q, rsp_d;
  ent_t cur, nw;
  logic [IdxW-1:0] ix;
  logic [TagWidth-1:0] rtgt;
  logic m;

  assign ix   = idx_q[IdxW-1:0];
  assign rtgt = TagWidth'(r_q.target_id);
  assign cur  = (idx_q < CntW'(QueueDepth)) ? ent_q[ix] : ent_q[0];

  always_comb begin
    nw.tm   = r_q.time_value;
    nw.what = r_q.what;
    nw.a1   = r_q.arg1;
    nw.a2   = r_q.arg2;
    nw.id   = TagWidth'(r_q.msg_id);
    nw.tgt  = rtgt;
    nw.run  = TagWidth'(r_q.runnable_id);
    nw.cb   = TagWidth'(r_q.callback_id);
  end

  always_comb begin
    m = 1'b1;
    if (rtgt != '0 && cur.tgt != rtgt) m = 1'b0;
    if (r_q.match_mask[0] && cur.id != TagWidth'(r_q.msg_id)) m = 1'b0;
    if (r_q.match_mask[1] && cur.what != r_q.what) m = 1'b0;
    if (r_q.match_mask[2] && ($signed(cur.what) < $signed(r_q.what) ||
        $signed(cur.what) > $signed(r_q.what_max))) m = 1'b0;
    if (r_q.match_mask[3] && cur.a1 != r_q.arg1) m = 1'b0;
    if (r_q.match_mask[4] && cur.a2 != r_q.arg2) m = 1'b0;
    if (r_q.match_mask[5] && cur.run != TagWidth'(r_q.runnable_id)) m = 1'b0;
    if (r_q.match_mask[6] && cur.cb != TagWidth'(r_q.callback_id)) m = 1'b0;
  end

  always_comb begin
    sts_o.func       = r_q.func;
    sts_o.tgt_zero   = (rtgt == '0);
    sts_o.safe       = safe_q;
    sts_o.exited     = exit_q;
    sts_o.full       = (cnt_q >= CntW'(QueueDepth));
    sts_o.empty      = (cnt_q == '0);
    sts_o.scan_end   = (idx_q >= cnt_q);
    sts_o.head_early = (r_q.time_value == 64'd0) || (r_q.time_value < ent_q[0].tm);
    sts_o.slot_le    = (cur.tm <= r_q.time_value);
    sts_o.head_due   = (ent_q[0].tm <= r_q.time_value);
    sts_o.match      = m;
    sts_o.hit        = hit_q;
  end

  always_comb begin
    ent_d  = ent_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    safe_d = safe_q | cmd_i.set_safe;
    exit_d = exit_q | cmd_i.set_exit;
    hit_d  = hit_q | cmd_i.hit_set;
    if (cmd_i.load) begin
      idx_d = '0;
      hit_d = 1'b0;
    end
    if (cmd_i.scan_inc) idx_d = idx_q + CntW'(1);
    if (cmd_i.ins_write) begin
      for (int i = 1; i < QueueDepth; i++) begin
        if (CntW'(i) > idx_q && CntW'(i) <= cnt_q) ent_d[i] = ent_q[i-1];
      end
      ent_d[ix] = nw;
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.del_slot) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        if (CntW'(i) >= idx_q) ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.clear) cnt_d = '0;
  end

  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.rsp_load) begin
      rsp_d = '0;
      rsp_d.status = cmd_i.status;
      rsp_d.queue_count = 5'(cnt_d);
      if (cmd_i.pop_out) begin
        rsp_d.out_msg_id      = 16'(ent_q[0].id);
        rsp_d.out_what        = ent_q[0].what;
        rsp_d.out_arg1        = ent_q[0].a1;
        rsp_d.out_arg2        = ent_q[0].a2;
        rsp_d.out_target_id   = 16'(ent_q[0].tgt);
        rsp_d.out_runnable_id = 16'(ent_q[0].run);
        rsp_d.out_callback_id = 16'(ent_q[0].cb);
      end
      if (cmd_i.wait_out) rsp_d.wait_time = ent_q[0].tm - r_q.time_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      safe_q <= 1'b0;
      exit_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      safe_q <= safe_d;
      exit_q <= exit_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (cmd_i.load) r_q <= req_i;
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

### sv/tmq_ctrl.sv
`default_nettype none
module tmq_ctrl import tmq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  sts_t      sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.rsp_load = 1'b1;
        state_d = S_DONE;
        case (sts_i.func)
          FUNC_ENQUEUE: begin
            if (sts_i.tgt_zero) cmd_o.status = ST_NO_TARGET;
            else if (sts_i.exited || sts_i.safe) cmd_o.status = ST_QUIT;
            else if (sts_i.full) cmd_o.status = ST_FULL;
            else if (sts_i.empty || sts_i.head_early) begin
              cmd_o.ins_write = 1'b1;
              cmd_o.status = ST_OK;
            end else begin
              cmd_o.rsp_load = 1'b0;
              cmd_o.scan_inc = 1'b1;
              state_d = S_INS;
            end
          end
          FUNC_POP_DUE: begin
            if (sts_i.exited) cmd_o.status = ST_QUIT;
            else if (sts_i.empty) cmd_o.status = sts_i.safe ? ST_QUIT : ST_EMPTY;
            else if (sts_i.head_due) begin
              cmd_o.del_slot = 1'b1;
              cmd_o.pop_out = 1'b1;
              cmd_o.status = ST_OK;
            end else begin
              cmd_o.wait_out = 1'b1;
              cmd_o.status = ST_NOT_DUE;
            end
          end
          FUNC_QUERY, FUNC_REMOVE_FIRST, FUNC_REMOVE_ALL: begin
            cmd_o.rsp_load = 1'b0;
            state_d = S_SCAN;
          end
          FUNC_QUIT_SAFE: begin
            if (sts_i.exited) cmd_o.status = ST_QUIT;
            else begin
              cmd_o.set_safe = 1'b1;
              cmd_o.status = ST_OK;
            end
          end
          FUNC_QUIT_NOW: begin
            if (sts_i.exited) cmd_o.status = ST_QUIT;
            else begin
              cmd_o.clear = 1'b1;
              cmd_o.set_exit = 1'b1;
              cmd_o.status = ST_OK;
            end
          end
          default: cmd_o.status = ST_OK;
        endcase
      end
      S_INS: begin
        if (!sts_i.scan_end && sts_i.slot_le) cmd_o.scan_inc = 1'b1;
        else begin
          cmd_o.ins_write = 1'b1;
          cmd_o.rsp_load = 1'b1;
          cmd_o.status = ST_OK;
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          cmd_o.rsp_load = 1'b1;
          cmd_o.status = sts_i.hit ? ST_FOUND : ST_NOT_FOUND;
          state_d = S_DONE;
        end else if (sts_i.match) begin
          if (sts_i.func == FUNC_QUERY) begin
            cmd_o.rsp_load = 1'b1;
            cmd_o.status = ST_FOUND;
            state_d = S_DONE;
          end else if (sts_i.func == FUNC_REMOVE_FIRST) begin
            cmd_o.del_slot = 1'b1;
            cmd_o.rsp_load = 1'b1;
            cmd_o.status = ST_FOUND;
            state_d = S_DONE;
          end else begin
            cmd_o.del_slot = 1'b1;
            cmd_o.hit_set = 1'b1;
          end
        end else cmd_o.scan_inc = 1'b1;
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

### sv/timed_message_queue_core.sv
`default_nettype none
// Time-ordered message queue. A transaction is taken when start is high and
// busy is low; its single result appears on rsp_o with done_o high for exactly
// one cycle, rsp_o holds it until the next result, and the receiver cannot stall
// it. Quit and most enqueue and pop cases pass from the decide state straight to
// the done state; an enqueue that walks the queue, a query or a removal first
// runs the controller's one-entry-per-cycle scan over the entry registers.
module timed_message_queue_core import tmq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault,
  parameter int unsigned TagWidth   = TagWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  req_t      req_i,
  output logic      busy,
  output logic      done_o,
  output rsp_t      rsp_o
);

  cmd_t cmd;
  sts_t sts;

  tmq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  tmq_datapath #(.QueueDepth(QueueDepth), .TagWidth(TagWidth)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;
  import tmq_pkg::*;

  localparam int Depth = 16;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  timed_message_queue_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #6 clk_i = ~clk_i;

  typedef struct {
    logic [63:0] tm;
    logic [31:0] what;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [15:0] id;
    logic [15:0] tgt;
    logic [15:0] run;
    logic [15:0] cb;
  } slot_t;

  slot_t held[$];
  bit safe_quit;
  bit hard_quit;
  rsp_t expected_rsp[$];
  req_t pending_req[$];
  int hold_off[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  int gap = 0;

  function automatic bit slot_matches(slot_t s, req_t r);
    if (r.target_id != 0 && s.tgt != r.target_id) return 0;
    if (r.match_mask[0] && s.id != r.msg_id) return 0;
    if (r.match_mask[1] && s.what != r.what) return 0;
    if (r.match_mask[2] && ($signed(s.what) < $signed(r.what) ||
        $signed(s.what) > $signed(r.what_max))) return 0;
    if (r.match_mask[3] && s.a1 != r.arg1) return 0;
    if (r.match_mask[4] && s.a2 != r.arg2) return 0;
    if (r.match_mask[5] && s.run != r.runnable_id) return 0;
    if (r.match_mask[6] && s.cb != r.callback_id) return 0;
    return 1;
  endfunction

  function automatic rsp_t queue_predict(req_t r);
    rsp_t o;
    slot_t s;
    int pos;
    bit hit;
    o = '0;
    hit = 0;
    case (r.func)
      FUNC_ENQUEUE: begin
        if (r.target_id == 0) o.status = ST_NO_TARGET;
        else if (hard_quit || safe_quit) o.status = ST_QUIT;
        else if (held.size() >= Depth) o.status = ST_FULL;
        else begin
          s = '{r.time_value, r.what, r.arg1, r.arg2, r.msg_id, r.target_id,
                r.runnable_id, r.callback_id};
          if (held.size() == 0 || r.time_value == 0 || r.time_value < held[0].tm) pos = 0;
          else begin
            pos = 1;
            while (pos < held.size() && held[pos].tm <= r.time_value) pos++;
          end
          held.insert(pos, s);
          o.status = ST_OK;
        end
      end
      FUNC_POP_DUE: begin
        if (hard_quit) o.status = ST_QUIT;
        else if (held.size() == 0) o.status = safe_quit ? ST_QUIT : ST_EMPTY;
        else if (held[0].tm <= r.time_value) begin
          s = held.pop_front();
          o.out_msg_id = s.id;
          o.out_what = s.what;
          o.out_arg1 = s.a1;
          o.out_arg2 = s.a2;
          o.out_target_id = s.tgt;
          o.out_runnable_id = s.run;
          o.out_callback_id = s.cb;
          o.status = ST_OK;
        end else begin
          o.wait_time = held[0].tm - r.time_value;
          o.status = ST_NOT_DUE;
        end
      end
      FUNC_QUERY: begin
        foreach (held[k]) if (slot_matches(held[k], r)) hit = 1;
        o.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end
      FUNC_REMOVE_FIRST: begin
        for (int k = 0; k < held.size(); k++) begin
          if (slot_matches(held[k], r)) begin
            held.delete(k);
            hit = 1;
            break;
          end
        end
        o.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end
      FUNC_REMOVE_ALL: begin
        pos = 0;
        while (pos < held.size()) begin
          if (slot_matches(held[pos], r)) begin
            held.delete(pos);
            hit = 1;
          end else pos++;
        end
        o.status = hit ? ST_FOUND : ST_NOT_FOUND;
      end
      FUNC_QUIT_SAFE: begin
        if (hard_quit) o.status = ST_QUIT;
        else begin
          safe_quit = 1;
          o.status = ST_OK;
        end
      end
      FUNC_QUIT_NOW: begin
        if (hard_quit) o.status = ST_QUIT;
        else begin
          held.delete();
          hard_quit = 1;
          o.status = ST_OK;
        end
      end
      default: o.status = ST_OK;
    endcase
    o.queue_count = 5'(held.size());
    return o;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      default: return $urandom();
    endcase
  endfunction

  // Small pools for tags and codes so that selections hit often.
  function automatic req_t rand_req(bit wellformed);
    req_t r;
    r = '0;
    r.func = wellformed ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
    if (wellformed && $urandom_range(0, 2) == 0) r.func = FUNC_ENQUEUE;
    r.time_value = $urandom_range(0, 3) == 0 ? {$urandom(), $urandom()}
                                              : 64'($urandom_range(0, 60));
    r.msg_id = $urandom_range(0, 5) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 5));
    r.what = $urandom_range(0, 3) == 0 ? rand_word() : 32'($urandom_range(0, 8)) - 4;
    r.what_max = $urandom_range(0, 3) == 0 ? rand_word() : 32'($urandom_range(0, 8)) - 4;
    r.arg1 = $urandom_range(0, 3) == 0 ? rand_word() : 32'($urandom_range(0, 3));
    r.arg2 = $urandom_range(0, 3) == 0 ? rand_word() : 32'($urandom_range(0, 3));
    r.target_id = $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3));
    r.runnable_id = $urandom_range(0, 5) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 2));
    r.callback_id = $urandom_range(0, 5) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 2));
    r.match_mask = $urandom_range(0, 1) ? 7'($urandom()) : 7'(1 << $urandom_range(0, 6));
    if (r.func == FUNC_ENQUEUE && wellformed && r.target_id == 0) r.target_id = 1;
    return r;
  endfunction

  task automatic push_item(req_t r, int g);
    pending_req.push_back(r);
    hold_off.push_back(g);
  endtask

  task automatic push_directed();
    req_t r;
    r = '0;
    r.func = FUNC_POP_DUE;
    push_item(r, 0);
    r.func = FUNC_QUERY;
    push_item(r, 0);
    r = '0;
    r.func = FUNC_ENQUEUE;
    push_item(r, 0);
    for (int k = 0; k < 17; k++) begin
      r = '1;
      r.func = FUNC_ENQUEUE;
      r.time_value = (k == 0) ? '1 : (k == 1) ? 64'd0 : 64'(k % 5 + 10);
      r.msg_id = 16'(k);
      r.what = k[0] ? 32'h8000_0000 : 32'h7fff_ffff;
      r.arg1 = k[1] ? '0 : '1;
      r.arg2 = k[2] ? '0 : '1;
      r.target_id = k[0] ? 16'hffff : 16'h0001;
      r.runnable_id = k[3] ? '0 : '1;
      r.callback_id = k[1] ? '0 : '1;
      push_item(r, k % 3);
    end
  endtask

  initial begin
    req_t r;
    int n;
    push_directed();
    r = '0;
    r.func = FUNC_POP_DUE;
    r.time_value = 64'd5;
    push_item(r, 1);
    r.func = FUNC_QUERY;
    r.match_mask = 7'h04;
    r.what = 32'h8000_0000;
    r.what_max = 32'h8000_0000;
    push_item(r, 0);
    r.func = FUNC_REMOVE_FIRST;
    r.target_id = 16'hffff;
    r.match_mask = 7'h00;
    push_item(r, 0);
    r.func = FUNC_REMOVE_ALL;
    r.target_id = 16'h0000;
    r.match_mask = 7'h02;
    r.what = 32'h7fff_ffff;
    push_item(r, 0);
    r = '0;
    r.func = FUNC_POP_DUE;
    r.time_value = '1;
    push_item(r, 0);
    r.func = FUNC_QUIT_SAFE;
    push_item(r, 0);
    r.func = 3'd7;
    push_item(r, 0);
    n = 0;
    while (n < 1800) begin
      for (int k = 0; k < 40 && n < 1800; k++, n++)
        push_item(rand_req($urandom_range(0, 9) != 0),
                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8));
      r = '0;
      r.func = $urandom_range(0, 1) ? FUNC_QUIT_NOW : FUNC_QUIT_SAFE;
      push_item(r, -1);
      n++;
    end
    for (int k = 0; k < 60; k++) push_item(rand_req(1), $urandom_range(0, 8));
    stim_done = 1;
  end

  // A hard quit cannot be undone without another reset, which is never applied,
  // so later items exercise the quit responses.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        start <= 1'b0;
      end else if (!start && pending_req.size() != 0) begin
        if (gap > 0) gap <= gap - 1;
        else if (hold_off[0] < 0 && expected_rsp.size() != 0) gap <= 0;
        else if (hold_off[0] > 0) begin
          gap <= hold_off[0];
          hold_off[0] = 0;
        end else begin
          req_i <= pending_req[0];
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      expected_rsp.push_back(queue_predict(pending_req[0]));
      void'(pending_req.pop_front());
      void'(hold_off.pop_front());
    end
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsp.pop_front();
        if (rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.out_msg_id !== e.out_msg_id) begin
          $error("out_msg_id exp %0h got %0h", e.out_msg_id, rsp_o.out_msg_id);
          errors++;
        end
        if (rsp_o.out_what !== e.out_what) begin
          $error("out_what exp %0h got %0h", e.out_what, rsp_o.out_what);
          errors++;
        end
        if (rsp_o.out_arg1 !== e.out_arg1) begin
          $error("out_arg1 exp %0h got %0h", e.out_arg1, rsp_o.out_arg1);
          errors++;
        end
        if (rsp_o.out_arg2 !== e.out_arg2) begin
          $error("out_arg2 exp %0h got %0h", e.out_arg2, rsp_o.out_arg2);
          errors++;
        end
        if (rsp_o.out_target_id !== e.out_target_id) begin
          $error("out_target_id exp %0h got %0h", e.out_target_id, rsp_o.out_target_id);
          errors++;
        end
        if (rsp_o.out_runnable_id !== e.out_runnable_id) begin
          $error("out_runnable_id exp %0h got %0h", e.out_runnable_id,
                 rsp_o.out_runnable_id);
          errors++;
        end
        if (rsp_o.out_callback_id !== e.out_callback_id) begin
          $error("out_callback_id exp %0h got %0h", e.out_callback_id,
                 rsp_o.out_callback_id);
          errors++;
        end
        if (rsp_o.wait_time !== e.wait_time) begin
          $error("wait_time exp %0h got %0h", e.wait_time, rsp_o.wait_time);
          errors++;
        end
        if (rsp_o.queue_count !== e.queue_count) begin
          $error("queue_count exp %0d got %0d", e.queue_count, rsp_o.queue_count);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_req.size() == 0 && !start && expected_rsp.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_rsp.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
